/* hw/rtl/catcp_pkg.sv */
// shared types and constants of the concatenation copy address generator
package catcp_pkg;

  localparam int IDX_W     = 32;
  localparam int MAX_DIMS  = 4;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_SIZE_1   = 3'd0,
    REG_OUT_SIZE_2   = 3'd1,
    REG_OUT_SIZE_3   = 3'd2,
    REG_OUT_STRIDE_0 = 3'd3,
    REG_OUT_STRIDE_1 = 3'd4,
    REG_OUT_STRIDE_2 = 3'd5,
    REG_OUT_STRIDE_3 = 3'd6,
    REG_CONCAT_DIM   = 3'd7
  } reg_idx_t;

  // size[k] holds the output size of dimension k+1
  typedef struct packed {
    logic [MAX_DIMS-2:0][IDX_W-1:0] size;
    logic [MAX_DIMS-1:0][IDX_W-1:0] ostr;
    logic [1:0]                     cdim;
  } cfg_t;

  // num is the value still to be split, rem/quo/den the running division
  typedef struct packed {
    logic [IDX_W-1:0]               idx;
    logic [IDX_W-1:0]               off;
    logic [IDX_W-1:0]               ext;
    logic                           contig;
    logic [MAX_DIMS-1:0][IDX_W-1:0] sstr;
    logic [MAX_DIMS-1:0][IDX_W-1:0] dig;
    logic [IDX_W-1:0]               num;
    logic [IDX_W-1:0]               rem;
    logic [IDX_W-1:0]               quo;
    logic [IDX_W-1:0]               den;
  } pkt_t;

endpackage

/* hw/rtl/catcp_div_step.sv */
// one restoring division step, one quotient bit per stage
module catcp_div_step #(
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  catcp_pkg::pkt_t   in_pkt,
  output logic              out_valid,
  output catcp_pkg::pkt_t   out_pkt
);

  logic [catcp_pkg::IDX_W:0]   trial;
  logic [catcp_pkg::IDX_W:0]   diff;
  logic                        ge;
  catcp_pkg::pkt_t             pkt_nxt;
  logic                        valid_r;
  catcp_pkg::pkt_t             pkt_r;

  always_comb begin
    trial   = {in_pkt.rem, in_pkt.num[BIT]};
    diff    = trial - {1'b0, in_pkt.den};
    ge      = trial >= {1'b0, in_pkt.den};
    pkt_nxt = in_pkt;
    pkt_nxt.rem = ge ? diff[catcp_pkg::IDX_W-1:0] : trial[catcp_pkg::IDX_W-1:0];
    pkt_nxt.quo = {in_pkt.quo[catcp_pkg::IDX_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pkt   = pkt_r;

endmodule

/* hw/rtl/catcp_mac.sv */
// digit times stride products and address sums, two stages
module catcp_mac #(
  parameter int NUM_DIMS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  catcp_pkg::cfg_t             cfg,
  input  logic                        in_valid,
  input  catcp_pkg::pkt_t             in_pkt,
  output logic                        out_valid,
  output logic [catcp_pkg::IDX_W-1:0] dst_address,
  output logic [catcp_pkg::IDX_W-1:0] src_address
);

  localparam int W = catcp_pkg::IDX_W;
  localparam int M = catcp_pkg::MAX_DIMS;

  logic [M-1:0][W-1:0] dig;
  logic [M-1:0][W-1:0] pd_nxt, ps_nxt;
  logic [W-1:0]        po_nxt;
  logic [M-1:0][W-1:0] pd_r, ps_r;
  logic [W-1:0]        po_r, idx_r;
  logic                contig_r, v1_r;
  logic [W-1:0]        dst_nxt, src_sum;
  logic [W-1:0]        dst_r, src_r;
  logic                v2_r;

  always_comb begin
    dig    = in_pkt.dig;
    dig[0] = in_pkt.num;
    for (int i = 0; i < M; i++) begin
      if (i < NUM_DIMS) begin
        pd_nxt[i] = W'(dig[i] * cfg.ostr[i]);
        ps_nxt[i] = W'(dig[i] * in_pkt.sstr[i]);
      end else begin
        pd_nxt[i] = '0;
        ps_nxt[i] = '0;
      end
    end
    po_nxt = W'(in_pkt.off * cfg.ostr[cfg.cdim]);
  end

  always_comb begin
    dst_nxt = po_r;
    src_sum = '0;
    for (int i = 0; i < M; i++) begin
      dst_nxt = dst_nxt + pd_r[i];
      src_sum = src_sum + ps_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd_r     <= pd_nxt;
      ps_r     <= ps_nxt;
      po_r     <= po_nxt;
      idx_r    <= in_pkt.idx;
      contig_r <= in_pkt.contig;
      dst_r    <= dst_nxt;
      src_r    <= contig_r ? idx_r : src_sum;
    end
  end

  assign out_valid   = v2_r;
  assign dst_address = dst_r;
  assign src_address = src_r;

endmodule

/* hw/rtl/concat_copy_address_generator.sv */
// top level of the concatenation copy address generator
//
//  channel | direction | handshake           | contents
//  in_     | in        | in_tvalid/in_tready | tdata: index, offset, extent, strides; tuser
//  out_    | out       | out_tvalid/out_tready | tdata: dst_address, src_address
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one word per cycle while out_tready keeps the pipe moving; a word passes the input
// register, then 32 divider stages plus a digit stage for each split dimension, then the MAC
// the whole pipe advances together and freezes while out_tvalid waits on out_tready
// synchronous reset clears valid bits and the configuration registers to their reset values
module concat_copy_address_generator #(
  parameter int NUM_DIMS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // elem_index, concat_offset, concat_extent, src_stride_0..src_stride_3
  input  logic [223:0] in_tdata,
  // is_contiguous
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // dst_address, src_address
  output logic [63:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int W  = catcp_pkg::IDX_W;
  localparam int NS = NUM_DIMS - 1;

  catcp_pkg::cfg_t cfg_r;
  logic            en;
  catcp_pkg::pkt_t in_pkt_r, in_pkt_nxt;
  logic            in_v_r;
  catcp_pkg::pkt_t stage_pkt [NUM_DIMS];
  logic            stage_v   [NUM_DIMS];
  logic [W-1:0]    dst_w, src_w;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size <= {W'(1), W'(1), W'(1)};
      cfg_r.ostr <= {W'(1), W'(0), W'(0), W'(0)};
      cfg_r.cdim <= '0;
    end else if (cfg_valid) begin
      unique case (catcp_pkg::reg_idx_t'(cfg_index))
        catcp_pkg::REG_OUT_SIZE_1:   cfg_r.size[0] <= cfg_data;
        catcp_pkg::REG_OUT_SIZE_2:   cfg_r.size[1] <= cfg_data;
        catcp_pkg::REG_OUT_SIZE_3:   cfg_r.size[2] <= cfg_data;
        catcp_pkg::REG_OUT_STRIDE_0: cfg_r.ostr[0] <= cfg_data;
        catcp_pkg::REG_OUT_STRIDE_1: cfg_r.ostr[1] <= cfg_data;
        catcp_pkg::REG_OUT_STRIDE_2: cfg_r.ostr[2] <= cfg_data;
        catcp_pkg::REG_OUT_STRIDE_3: cfg_r.ostr[3] <= cfg_data;
        catcp_pkg::REG_CONCAT_DIM:   cfg_r.cdim    <= cfg_data[1:0];
      endcase
    end
  end

  always_comb begin
    in_pkt_nxt         = '0;
    in_pkt_nxt.idx     = in_tdata[31:0];
    in_pkt_nxt.off     = in_tdata[63:32];
    in_pkt_nxt.ext     = in_tdata[95:64];
    in_pkt_nxt.contig  = in_tuser;
    in_pkt_nxt.sstr[0] = in_tdata[127:96];
    in_pkt_nxt.sstr[1] = in_tdata[159:128];
    in_pkt_nxt.sstr[2] = in_tdata[191:160];
    in_pkt_nxt.sstr[3] = in_tdata[223:192];
    in_pkt_nxt.num     = in_tdata[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (en) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_pkt_r <= in_pkt_nxt;
    end
  end

  assign stage_pkt[0] = in_pkt_r;
  assign stage_v[0]   = in_v_r;

  // innermost dimension is split first
  for (genvar j = 0; j < NS; j++) begin : g_dim
    localparam int D = NUM_DIMS - 1 - j;

    catcp_pkg::pkt_t chain [W+1];
    logic            cv    [W+1];
    catcp_pkg::pkt_t prep;
    catcp_pkg::pkt_t fin_nxt;
    catcp_pkg::pkt_t fin_r;
    logic            fin_v_r;

    always_comb begin
      prep     = stage_pkt[j];
      prep.rem = '0;
      prep.quo = '0;
      prep.den = (cfg_r.cdim == 2'(D)) ? stage_pkt[j].ext : cfg_r.size[2'(D - 1)];
    end

    assign chain[0] = prep;
    assign cv[0]    = stage_v[j];

    for (genvar k = 0; k < W; k++) begin : g_bit
      catcp_div_step #(.BIT(W - 1 - k)) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (cv[k]),
        .in_pkt   (chain[k]),
        .out_valid(cv[k+1]),
        .out_pkt  (chain[k+1])
      );
    end

    // zero radix keeps the whole value as the digit
    always_comb begin
      fin_nxt = chain[W];
      if (chain[W].den == '0) begin
        fin_nxt.dig[D] = chain[W].num;
        fin_nxt.num    = '0;
      end else begin
        fin_nxt.dig[D] = chain[W].rem;
        fin_nxt.num    = chain[W].quo;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        fin_v_r <= 1'b0;
      end else if (en) begin
        fin_v_r <= cv[W];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fin_r <= fin_nxt;
      end
    end

    assign stage_pkt[j+1] = fin_r;
    assign stage_v[j+1]   = fin_v_r;
  end

  catcp_mac #(.NUM_DIMS(NUM_DIMS)) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .cfg        (cfg_r),
    .in_valid   (stage_v[NS]),
    .in_pkt     (stage_pkt[NS]),
    .out_valid  (out_tvalid),
    .dst_address(dst_w),
    .src_address(src_w)
  );

  assign out_tdata = {src_w, dst_w};

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid && !in_v_r)
    else $error("valid bits survive reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> in_v_r)
    else $error("accepted word missing from first stage");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(in_v_r) && $stable(stage_v[NS]))
    else $error("pipeline moved during stall");

endmodule

/* test/tb_concat_copy_address_generator.sv */
// testbench of the concatenation copy address generator: random and directed words
module tb_concat_copy_address_generator;

  typedef struct {
    logic [31:0] idx;
    logic [31:0] off;
    logic [31:0] ext;
    logic        contig;
    logic [31:0] sstr [4];
  } addr_req_t;

  class addr_scoreboard;
    logic [31:0] osize [4];
    logic [31:0] ostride [4];
    logic [1:0]  cdim;
    logic [63:0] pending [$];
    int          errors;
    int          checked;

    function void set_reset();
      for (int i = 0; i < 4; i++) begin
        osize[i] = 1;
        ostride[i] = 0;
      end
      ostride[3] = 1;
      cdim = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(catcp_pkg::reg_idx_t r, logic [31:0] v);
      case (r)
        catcp_pkg::REG_OUT_SIZE_1:   osize[1] = v;
        catcp_pkg::REG_OUT_SIZE_2:   osize[2] = v;
        catcp_pkg::REG_OUT_SIZE_3:   osize[3] = v;
        catcp_pkg::REG_OUT_STRIDE_0: ostride[0] = v;
        catcp_pkg::REG_OUT_STRIDE_1: ostride[1] = v;
        catcp_pkg::REG_OUT_STRIDE_2: ostride[2] = v;
        catcp_pkg::REG_OUT_STRIDE_3: ostride[3] = v;
        catcp_pkg::REG_CONCAT_DIM:   cdim = v[1:0];
        default: ;
      endcase
    endfunction

    // mixed-radix split, then both weighted sums
    function void note_word(addr_req_t r);
      logic [31:0] dig [4];
      logic [31:0] rest, radix, dst, src;
      rest = r.idx;
      for (int i = 3; i >= 1; i--) begin
        radix = (i == cdim) ? r.ext : osize[i];
        if (radix == 0) begin
          dig[i] = rest;
          rest = 0;
        end else begin
          dig[i] = rest % radix;
          rest = rest / radix;
        end
      end
      dig[0] = rest;
      dst = r.off * ostride[cdim];
      src = 0;
      for (int i = 0; i < 4; i++) begin
        dst += dig[i] * ostride[i];
        src += dig[i] * r.sstr[i];
      end
      if (r.contig) src = r.idx;
      pending.push_back({src, dst});
    endfunction

    function void check_word(logic [63:0] got);
      logic [63:0] exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got[31:0] !== exp[31:0]) begin
        $display("%0t: dst_address expected %h actual %h", $time, exp[31:0], got[31:0]);
        errors++;
      end
      if (got[63:32] !== exp[63:32]) begin
        $display("%0t: src_address expected %h actual %h", $time, exp[63:32], got[63:32]);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [223:0] in_tdata = '0;
  logic         in_tuser = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [63:0]  out_tdata;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  addr_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  cycles = 0;
  localparam int LATENCY = 3 + 33 * 3;
  localparam int CYCLE_LIMIT = 400000;

  concat_copy_address_generator u_top (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL concat_copy_address_generator");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(catcp_pkg::reg_idx_t r, logic [31:0] v);
    cfg_valid <= 1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(r, v);
    cfg_valid <= 0;
  endtask

  task automatic send_word(addr_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {r.sstr[3], r.sstr[2], r.sstr[1], r.sstr[0], r.ext, r.off, r.idx};
    in_tuser  <= r.contig;
    do @(posedge clk); while (!in_tready);
    sb.note_word(r);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // mostly small values so digits are non-trivial, with the odd full-range or zero one
  function automatic logic [31:0] pick(int lo, int hi);
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'hffffffff;
      2: return 0;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic addr_req_t rand_word();
    addr_req_t r;
    r.idx = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(5000);
    r.off = pick(0, 20);
    r.ext = pick(1, 9);
    r.contig = 1'($urandom_range(1));
    for (int i = 0; i < 4; i++) r.sstr[i] = pick(0, 100);
    return r;
  endfunction

  task automatic set_config(logic [31:0] s1, logic [31:0] s2, logic [31:0] s3,
                            logic [31:0] t0, logic [31:0] t1, logic [31:0] t2,
                            logic [31:0] t3, logic [1:0] cd);
    write_reg(catcp_pkg::REG_OUT_SIZE_1, s1);
    write_reg(catcp_pkg::REG_OUT_SIZE_2, s2);
    write_reg(catcp_pkg::REG_OUT_SIZE_3, s3);
    write_reg(catcp_pkg::REG_OUT_STRIDE_0, t0);
    write_reg(catcp_pkg::REG_OUT_STRIDE_1, t1);
    write_reg(catcp_pkg::REG_OUT_STRIDE_2, t2);
    write_reg(catcp_pkg::REG_OUT_STRIDE_3, t3);
    write_reg(catcp_pkg::REG_CONCAT_DIM, {30'd0, cd});
  endtask

  initial begin
    addr_req_t r;
    sb.set_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed edge-value words: reset registers first, then a register setting with edge values
    for (int k = 0; k < 20; k++) begin
      r.idx = (k % 4 == 0) ? 32'hffffffff : (k % 4 == 1) ? 0 : k * 7;
      r.off = (k % 3 == 0) ? 32'hffffffff : k;
      r.ext = (k % 5 == 0) ? 32'hffffffff : (k % 5 == 1) ? 0 : k + 1;
      r.contig = k[0];
      for (int i = 0; i < 4; i++) r.sstr[i] = (k % 2) ? 32'hffffffff : i + k;
      if (k == 10) begin
        drain();
        set_config(3, 0, 5, 32'hffffffff, 7, 0, 2, 2'd2);
      end
      send_word(r);
    end
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 82 : 0;
      recv_idle_pct = (ph < 2) ? 82 : (ph < 4) ? 7 : 0;
      case (ph)
        0: set_config(4, 3, 5, 60, 15, 5, 1, 2'd1);
        1: set_config(32'hffffffff, 32'hffffffff, 32'hffffffff,
                      32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 2'd3);
        2: set_config(2, 7, 3, 100, 21, 3, 1, 2'd2);
        3: set_config(1, 1, 1, 0, 0, 0, 0, 2'd0);
        default: set_config($urandom_range(9), $urandom_range(9), $urandom_range(9),
                            $urandom(), $urandom_range(50), $urandom_range(9),
                            $urandom_range(3), 2'($urandom_range(3)));
      endcase
      for (int n = 0; n < 125; n++) begin
        if (n == 60) begin
          // sender holds off until the pipe is empty
          in_tvalid <= 0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
        send_word(rand_word());
      end
      drain();
    end

    $display("covered %0d results over eight register settings", sb.checked);
    $display("zero and full-range sizes, extents, strides, offsets; all concat dims");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS concat_copy_address_generator");
    end else begin
      $display("FAIL concat_copy_address_generator");
    end
    $finish;
  end
endmodule

/* concat_copy_address_generator.f */
hw/rtl/catcp_pkg.sv
hw/rtl/catcp_div_step.sv
hw/rtl/catcp_mac.sv
hw/rtl/concat_copy_address_generator.sv
test/tb_concat_copy_address_generator.sv
